>>> design/assert_macros.svh
// assertion macros used by the checker file cpu8_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define CPU8_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("cpu8 assertion failed");

// property checked on every edge, reset included
`define CPU8_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cpu8 assertion failed");

`endif

>>> design/cpu8_pkg.sv
// shared types, operation codes and constants of the cpu8 execute core
// no dependencies
package cpu8_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] FLAGS_RESET = 8'h20;
    localparam logic [7:0] SP_RESET    = 8'hFD;

    typedef enum logic [5:0] {
        ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
        ACT_EOR = 6'd4,  ACT_BIT = 6'd5,  ACT_CMP = 6'd6,  ACT_CPX = 6'd7,
        ACT_CPY = 6'd8,  ACT_LDA = 6'd9,  ACT_LDX = 6'd10, ACT_LDY = 6'd11,
        ACT_INC = 6'd12, ACT_DEC = 6'd13, ACT_INX = 6'd14, ACT_INY = 6'd15,
        ACT_DEX = 6'd16, ACT_DEY = 6'd17, ACT_ASL = 6'd18, ACT_LSR = 6'd19,
        ACT_ROL = 6'd20, ACT_ROR = 6'd21, ACT_TAX = 6'd22, ACT_TAY = 6'd23,
        ACT_TXA = 6'd24, ACT_TYA = 6'd25, ACT_TSX = 6'd26, ACT_TXS = 6'd27,
        ACT_CLC = 6'd28, ACT_CLD = 6'd29, ACT_CLI = 6'd30, ACT_CLV = 6'd31,
        ACT_SEC = 6'd32, ACT_SED = 6'd33, ACT_SEI = 6'd34, ACT_STA = 6'd35,
        ACT_STX = 6'd36, ACT_STY = 6'd37
    } action_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] sp;
    } regs_t;

    typedef struct packed {
        logic [5:0] action;
        logic [7:0] operand;
        logic       on_accumulator;
    } item_t;

    typedef struct packed {
        logic [7:0] result_value;
        logic       mem_write;
        logic [7:0] status_out;
        logic [7:0] accumulator_out;
    } result_t;

endpackage

>>> design/cpu8_alu.sv
// combinational alu and register update of the cpu8 execute core
// depends on cpu8_pkg
module cpu8_alu (
    input  cpu8_pkg::item_t   item,
    input  cpu8_pkg::regs_t   regs,
    output cpu8_pkg::regs_t   regs_next,
    output cpu8_pkg::result_t result
);

    logic [7:0] m;
    logic [7:0] m_eff;
    logic [8:0] sum;
    logic [7:0] cmp_src;
    logic [8:0] diff;
    logic [7:0] sh_src;
    logic [7:0] p;
    logic [7:0] val;
    logic       wr;

    function automatic logic [7:0] with_nz(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f = flags;
        f[cpu8_pkg::FLAG_Z] = (v == 8'h00);
        f[cpu8_pkg::FLAG_N] = v[7];
        return f;
    endfunction

    assign m       = item.operand;
    assign m_eff   = (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_SBC) ? ~m : m;
    assign sum     = {1'b0, regs.a} + {1'b0, m_eff} + {8'h00, regs.p[cpu8_pkg::FLAG_C]};
    assign diff    = {1'b0, cmp_src} - {1'b0, m};
    assign sh_src  = item.on_accumulator ? regs.a : m;

    always_comb begin
        unique case (cpu8_pkg::action_t'(item.action))
            cpu8_pkg::ACT_CPX: cmp_src = regs.x;
            cpu8_pkg::ACT_CPY: cmp_src = regs.y;
            default:           cmp_src = regs.a;
        endcase
    end

    always_comb begin
        regs_next = regs;
        p = regs.p;
        p[cpu8_pkg::FLAG_U] = 1'b1;
        val = 8'h00;
        wr  = 1'b0;
        unique case (cpu8_pkg::action_t'(item.action))
            cpu8_pkg::ACT_ADC, cpu8_pkg::ACT_SBC: begin
                val = sum[7:0];
                p[cpu8_pkg::FLAG_C] = sum[8];
                p[cpu8_pkg::FLAG_V] = ~(regs.a[7] ^ m_eff[7]) & (regs.a[7] ^ sum[7]);
                p = with_nz(p, val);
                regs_next.a = val;
            end
            cpu8_pkg::ACT_AND, cpu8_pkg::ACT_ORA, cpu8_pkg::ACT_EOR: begin
                if (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_AND) begin
                    val = regs.a & m;
                end else if (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_ORA) begin
                    val = regs.a | m;
                end else begin
                    val = regs.a ^ m;
                end
                p = with_nz(p, val);
                regs_next.a = val;
            end
            cpu8_pkg::ACT_BIT: begin
                p[cpu8_pkg::FLAG_Z] = ((regs.a & m) == 8'h00);
                p[cpu8_pkg::FLAG_N] = m[7];
                p[cpu8_pkg::FLAG_V] = m[6];
            end
            cpu8_pkg::ACT_CMP, cpu8_pkg::ACT_CPX, cpu8_pkg::ACT_CPY: begin
                val = diff[7:0];
                p[cpu8_pkg::FLAG_C] = ~diff[8];
                p = with_nz(p, val);
            end
            cpu8_pkg::ACT_LDA: begin
                val = m; p = with_nz(p, val); regs_next.a = val;
            end
            cpu8_pkg::ACT_LDX: begin
                val = m; p = with_nz(p, val); regs_next.x = val;
            end
            cpu8_pkg::ACT_LDY: begin
                val = m; p = with_nz(p, val); regs_next.y = val;
            end
            cpu8_pkg::ACT_INC: begin
                val = m + 8'd1; p = with_nz(p, val); wr = 1'b1;
            end
            cpu8_pkg::ACT_DEC: begin
                val = m - 8'd1; p = with_nz(p, val); wr = 1'b1;
            end
            cpu8_pkg::ACT_INX: begin
                val = regs.x + 8'd1; p = with_nz(p, val); regs_next.x = val;
            end
            cpu8_pkg::ACT_INY: begin
                val = regs.y + 8'd1; p = with_nz(p, val); regs_next.y = val;
            end
            cpu8_pkg::ACT_DEX: begin
                val = regs.x - 8'd1; p = with_nz(p, val); regs_next.x = val;
            end
            cpu8_pkg::ACT_DEY: begin
                val = regs.y - 8'd1; p = with_nz(p, val); regs_next.y = val;
            end
            cpu8_pkg::ACT_ASL, cpu8_pkg::ACT_LSR, cpu8_pkg::ACT_ROL, cpu8_pkg::ACT_ROR: begin
                if (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_ASL) begin
                    val = {sh_src[6:0], 1'b0};
                    p[cpu8_pkg::FLAG_C] = sh_src[7];
                end else if (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_LSR) begin
                    val = {1'b0, sh_src[7:1]};
                    p[cpu8_pkg::FLAG_C] = sh_src[0];
                end else if (cpu8_pkg::action_t'(item.action) == cpu8_pkg::ACT_ROL) begin
                    val = {sh_src[6:0], regs.p[cpu8_pkg::FLAG_C]};
                    p[cpu8_pkg::FLAG_C] = sh_src[7];
                end else begin
                    val = {regs.p[cpu8_pkg::FLAG_C], sh_src[7:1]};
                    p[cpu8_pkg::FLAG_C] = sh_src[0];
                end
                p = with_nz(p, val);
                if (item.on_accumulator) begin
                    regs_next.a = val;
                end else begin
                    wr = 1'b1;
                end
            end
            cpu8_pkg::ACT_TAX: begin
                val = regs.a; p = with_nz(p, val); regs_next.x = val;
            end
            cpu8_pkg::ACT_TAY: begin
                val = regs.a; p = with_nz(p, val); regs_next.y = val;
            end
            cpu8_pkg::ACT_TXA: begin
                val = regs.x; p = with_nz(p, val); regs_next.a = val;
            end
            cpu8_pkg::ACT_TYA: begin
                val = regs.y; p = with_nz(p, val); regs_next.a = val;
            end
            cpu8_pkg::ACT_TSX: begin
                val = regs.sp; p = with_nz(p, val); regs_next.x = val;
            end
            cpu8_pkg::ACT_TXS: begin
                val = regs.x; regs_next.sp = val;
            end
            cpu8_pkg::ACT_CLC: p[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::ACT_CLD: p[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::ACT_CLI: p[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::ACT_CLV: p[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::ACT_SEC: p[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::ACT_SED: p[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::ACT_SEI: p[cpu8_pkg::FLAG_I] = 1'b1;
            cpu8_pkg::ACT_STA: begin
                val = regs.a; wr = 1'b1;
            end
            cpu8_pkg::ACT_STX: begin
                val = regs.x; wr = 1'b1;
            end
            cpu8_pkg::ACT_STY: begin
                val = regs.y; wr = 1'b1;
            end
            default: begin
            end
        endcase
        p[cpu8_pkg::FLAG_U] = 1'b1;
        regs_next.p = p;
        result.result_value    = val;
        result.mem_write       = wr;
        result.status_out      = p;
        result.accumulator_out = regs_next.a;
    end

endmodule

>>> design/cpu8_register_alu_execute_core.sv
// Execute core of an 8-bit accumulator cpu: holds A, X, Y, SP and NV-BDIZC status and runs
// one operation per input word through a combinational alu, binary arithmetic only. It takes
// one word per clock while the result side is not stalled; a word passes through the input
// register, then the alu and the result register, and back-pressure on the result side stalls
// both stages. Each operation sees the register state left by the one before it.
// depends on cpu8_pkg and cpu8_alu
module cpu8_register_alu_execute_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action [5:0], operand [13:6], on_accumulator [14], zero [15]
    input  logic [cpu8_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_value [7:0], mem_write [8], status_out [16:9], accumulator_out [24:17], zero [31:25]
    output logic [cpu8_pkg::M_TDATA_W-1:0]   m_tdata
);

    cpu8_pkg::regs_t   regs_reg;
    cpu8_pkg::regs_t   regs_next;
    cpu8_pkg::item_t   item_reg;
    cpu8_pkg::result_t alu_result;
    cpu8_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    cpu8_alu u_alu (
        .item      (item_reg),
        .regs      (regs_reg),
        .regs_next (regs_next),
        .result    (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg.a    <= 8'h00;
            regs_reg.x    <= 8'h00;
            regs_reg.y    <= 8'h00;
            regs_reg.p    <= cpu8_pkg::FLAGS_RESET;
            regs_reg.sp   <= cpu8_pkg::SP_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                regs_reg <= regs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action         <= s_tdata[5:0];
            item_reg.operand        <= s_tdata[13:6];
            item_reg.on_accumulator <= s_tdata[14];
        end
        if (fire) begin
            out_reg <= alu_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cpu8_pkg::M_TDATA_W - 25){1'b0}}, out_reg.accumulator_out,
                       out_reg.status_out, out_reg.mem_write, out_reg.result_value};

endmodule

>>> design/cpu8_checker.sv
// port-level checks of the cpu8 execute core, bound to the top level
// depends on assert_macros.svh and cpu8_pkg
`include "assert_macros.svh"

module cpu8_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cpu8_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result word holds
    `CPU8_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // reset empties the result stage
    `CPU8_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // unused status bit always reads one
    `CPU8_ASSERT(a_flag_u_set, aclk, aresetn, m_tvalid |-> m_tdata[9 + cpu8_pkg::FLAG_U])
    // break bit is never touched, stays clear
    `CPU8_ASSERT(a_flag_b_clear, aclk, aresetn, m_tvalid |-> !m_tdata[9 + cpu8_pkg::FLAG_B])

endmodule

bind cpu8_register_alu_execute_core cpu8_checker u_cpu8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
